[hdl/vwg_pkg.sv]
// Shared types, register indexes and helpers for the voltammetry waveform generator.
package vwg_pkg;

   localparam int CSR_IDX_W = 3;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_START_LEVEL  = 3'd0;
   localparam csr_idx_type CSR_PEAK_LEVEL   = 3'd1;
   localparam csr_idx_type CSR_SQUARE_MODE  = 3'd2;
   localparam csr_idx_type CSR_STEP_SIZE    = 3'd3;
   localparam csr_idx_type CSR_PULSE_HEIGHT = 3'd4;

   typedef enum logic [1:0] {
      LEG_RISE  = 2'd0,
      LEG_FALL  = 2'd1,
      LEG_FINAL = 2'd2
   } leg_type;

   typedef struct packed {
      logic [7:0] sample;
      logic [9:0] sample_index;
      logic       last;
      logic       truncated;
   } rsp_type;

   // saturate a small signed value into DAC range
   function automatic logic [7:0] clamp8(input logic signed [9:0] x);
      logic [7:0] r;
      if (x < 0) begin
         r = 8'd0;
      end else if (x > 10'sd255) begin
         r = 8'd255;
      end else begin
         r = x[7:0];
      end
      return r;
   endfunction

endpackage

[hdl/voltammetry_waveform_generator.sv]
// Voltammetry waveform generator: cyclic sweep or square-wave staircase, one sample per beat.
// An accepted beat's sample is registered in the holding register, or the skid if it stalls.
// One beat per cycle unless the skid is full; state advances in one combinational pass.
// A two-deep output stage (holding register plus skid) keeps req_tready high while one
// finished sample waits on a stalled rsp side.
// Reset (synchronous, active high): registers to their defaults, waveform at index 0, rsp empty.
module voltammetry_waveform_generator #(
   parameter int LUT_DEPTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [0] restart, [7:1] zero
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // [7:0] sample, [17:8] sample_index, [23:18] zero
   output logic                  rsp_tlast,   // last sample of the waveform
   output logic                  rsp_tuser,   // [0] truncated
   // register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  vwg_pkg::csr_idx_type  csr_index,
   input  logic [7:0]            csr_data
);
   import vwg_pkg::*;

   localparam int PW = (LUT_DEPTH > 1) ? $clog2(LUT_DEPTH) : 1;
   localparam logic [PW-1:0] POS_MAX = PW'(LUT_DEPTH - 1);

   // ---------------------------------------------------------------- registers
   logic [7:0] start_level_ff, peak_level_ff, step_size_ff, pulse_height_ff;
   logic       square_mode_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_level_ff  <= 8'd0;
         peak_level_ff   <= 8'd255;
         square_mode_ff  <= 1'b0;
         step_size_ff    <= 8'd1;
         pulse_height_ff <= 8'd0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_START_LEVEL:  start_level_ff  <= csr_data;
            CSR_PEAK_LEVEL:   peak_level_ff   <= csr_data;
            CSR_SQUARE_MODE:  square_mode_ff  <= csr_data[0];
            CSR_STEP_SIZE:    step_size_ff    <= csr_data;
            CSR_PULSE_HEIGHT: pulse_height_ff <= csr_data;
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------- waveform state
   leg_type       leg_ff, leg_in;
   logic [7:0]    level_ff, level_in;
   logic          low_half_ff, low_half_in;
   logic [PW-1:0] pos_ff, pos_in;

   logic req_fire;
   assign req_fire = req_tvalid && req_tready;

   // fresh start on restart or at index 0: reload from the registers
   logic          fresh;
   leg_type       e_leg;
   logic [7:0]    e_level;
   logic          e_low;
   logic [PW-1:0] e_pos;

   assign fresh   = req_tdata[0] || (pos_ff == '0);
   assign e_leg   = fresh ? LEG_RISE       : leg_ff;
   assign e_level = fresh ? start_level_ff : level_ff;
   assign e_low   = fresh ? 1'b0           : low_half_ff;
   assign e_pos   = fresh ? '0             : pos_ff;

   // shared step datapath: one add or subtract, one compare against the leg's target
   logic              up_asc, down_asc, dir_asc;
   logic [7:0]        inc, target;
   logic signed [9:0] v_s, nv, tgt_s, half_s, hi_s, lo_s;
   logic              in_range;

   assign up_asc   = start_level_ff < peak_level_ff;
   assign down_asc = peak_level_ff < start_level_ff;
   assign inc      = square_mode_ff ? step_size_ff : 8'd1;
   assign dir_asc  = (e_leg == LEG_RISE) ? up_asc : down_asc;
   assign target   = (e_leg == LEG_RISE) ? peak_level_ff : start_level_ff;

   assign v_s      = signed'({2'b00, e_level});
   assign tgt_s    = signed'({2'b00, target});
   assign nv       = dir_asc ? v_s + signed'({2'b00, inc}) : v_s - signed'({2'b00, inc});
   assign in_range = dir_asc ? (nv <= tgt_s) : (nv >= tgt_s);

   assign half_s = signed'({3'b000, pulse_height_ff[7:1]});
   assign hi_s   = v_s + half_s;
   assign lo_s   = v_s - half_s;

   // linear turn: first level of the down leg, one past the peak toward start
   logic [7:0] turn_level;
   assign turn_level = down_asc ? peak_level_ff + 8'd1 : peak_level_ff - 8'd1;

   logic natural, cut;

   // next state
   always_comb begin
      leg_in      = e_leg;
      level_in    = e_level;
      low_half_in = e_low;
      natural     = 1'b0;
      case (e_leg)
         LEG_RISE: begin
            if (!square_mode_ff) begin
               low_half_in = 1'b0;
               if (in_range) begin
                  level_in = nv[7:0];
               end else if (start_level_ff != peak_level_ff) begin
                  leg_in   = LEG_FALL;
                  level_in = turn_level;
               end else begin
                  leg_in = LEG_FINAL;
               end
            end else if (!e_low) begin
               if (in_range) begin
                  low_half_in = 1'b1;
               end else begin
                  // peak stair: its low sample gives way to the down leg
                  leg_in      = LEG_FALL;
                  level_in    = peak_level_ff;
                  low_half_in = 1'b0;
               end
            end else begin
               low_half_in = 1'b0;
               if (in_range) begin
                  level_in = nv[7:0];
               end else begin
                  leg_in   = LEG_FALL;
                  level_in = peak_level_ff;
               end
            end
         end
         LEG_FALL: begin
            if (square_mode_ff && !e_low) begin
               low_half_in = 1'b1;
            end else begin
               low_half_in = 1'b0;
               if (in_range) begin
                  level_in = nv[7:0];
               end else begin
                  leg_in = LEG_FINAL;
               end
            end
         end
         default: begin
            natural = 1'b1;
         end
      endcase
   end

   // sample select
   logic [7:0] smp;
   always_comb begin
      case (e_leg)
         LEG_RISE, LEG_FALL: begin
            if (!square_mode_ff) begin
               smp = e_level;
            end else if (!e_low) begin
               smp = clamp8(hi_s);
            end else begin
               smp = clamp8(lo_s);
            end
         end
         default: smp = start_level_ff;
      endcase
   end

   assign cut    = !natural && (e_pos == POS_MAX);
   assign pos_in = (natural || cut) ? '0 : e_pos + PW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         leg_ff      <= LEG_RISE;
         level_ff    <= 8'd0;
         low_half_ff <= 1'b0;
         pos_ff      <= '0;
      end else if (req_fire) begin
         leg_ff      <= (natural || cut) ? LEG_RISE : leg_in;
         level_ff    <= level_in;
         low_half_ff <= (natural || cut) ? 1'b0 : low_half_in;
         pos_ff      <= pos_in;
      end
   end

   rsp_type new_rsp;
   assign new_rsp.sample       = smp;
   assign new_rsp.sample_index = 10'(e_pos);
   assign new_rsp.last         = natural || cut;
   assign new_rsp.truncated    = cut;

   // ---------------------------------------------------------------- output stage + skid
   rsp_type out_ff, skid_ff;
   logic    out_valid_ff, skid_valid_ff;
   logic    pop;

   assign req_tready = !skid_valid_ff;
   assign pop        = out_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (req_fire) begin
         if (out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (req_fire) begin
         if (out_valid_ff && !pop) begin
            skid_ff <= new_rsp;
         end else begin
            out_ff <= new_rsp;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_ff.sample_index, out_ff.sample};
   assign rsp_tlast  = out_ff.last;
   assign rsp_tuser  = out_ff.truncated;

endmodule
